[src/ilha_pkg.sv]
// shared types, codes and helpers for the implicit list heap allocator
`timescale 1ns / 1ps
package ilha_pkg;

    localparam int HEAP_BYTES_DEF  = 65536;
    localparam int CHUNK_BYTES_DEF = 4096;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_OOM  = 2'd2;

    localparam logic [31:0] BIT_ALLOC = 32'h1;
    localparam logic [31:0] BIT_PREV  = 32'h2;
    localparam logic [31:0] BOTH_BITS = 32'h3;
    localparam logic [31:0] OFF_M4    = 32'hFFFF_FFFC;
    localparam logic [31:0] OFF_M8    = 32'hFFFF_FFF8;
    localparam logic [31:0] LIST_START = 32'd8;

    typedef enum logic [5:0] {
        ST_CLEAR, ST_INIT, ST_IDLE, ST_START,
        ST_FF_RD, ST_FF_USE, ST_GROW_CHK,
        ST_GR_RD, ST_GR_W0, ST_GR_W1, ST_GR_W2,
        ST_MG_RD0, ST_MG_RD1, ST_MG_DEC,
        ST_MP_W0, ST_MP_W1,
        ST_MN_A, ST_MN_B, ST_MN_C, ST_MN_D,
        ST_MB_A, ST_MB_B, ST_MB_C, ST_MB_D, ST_MB_E,
        ST_MG_END,
        ST_TK_RD, ST_TK_DEC, ST_TK_NR, ST_TK_NW, ST_TK_S1, ST_TK_S2,
        ST_RL0, ST_RL1, ST_RL2, ST_RL3, ST_RL4,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        idle;
        logic        done;
        logic [15:0] addr;
        logic [1:0]  stat;
    } t_seq_status;

    function automatic logic [31:0] f_size(input logic [31:0] w);
        return {w[31:3], 3'b000};
    endfunction

endpackage

[src/ilha_agu.sv]
// address unit shared by every heap access: byte offset sum to word index
`timescale 1ns / 1ps
module ilha_agu #(
    parameter int IDX_W = 14
) (
    input  logic [31:0]      i_base,
    input  logic [31:0]      i_off,
    output logic [IDX_W-1:0] o_idx
);
    logic [31:0] s_sum;

    assign s_sum = i_base + i_off;
    // low two bits dropped, upper bits wrap around the heap
    assign o_idx = s_sum[IDX_W+1:2];
endmodule

[src/ilha_ram.sv]
// single port heap word memory with registered read
`timescale 1ns / 1ps
module ilha_ram #(
    parameter int IDX_W = 14
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [31:0]      i_wdata,
    output logic [31:0]      o_rdata
);
    logic [31:0] r_mem [0:(1<<IDX_W)-1];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_idx] <= i_wdata;
        end
        r_rdata <= r_mem[i_idx];
    end

    assign o_rdata = r_rdata;
endmodule

[src/ilha_seq.sv]
// allocator sequencer: one heap access per cycle through the shared address unit
`timescale 1ns / 1ps
module ilha_seq
    import ilha_pkg::*;
#(
    parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
    parameter int IDX_W       = $clog2(HEAP_BYTES / 4)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_command,
    input  logic [15:0] i_request_bytes,
    input  logic [15:0] i_block_address,
    input  logic        i_slot_free,
    output t_seq_status o_status
);
    localparam logic [31:0] HEAP_B = 32'(HEAP_BYTES);
    localparam logic [31:0] CHUNK_B = 32'(CHUNK_BYTES);
    localparam logic [31:0] B0 =
        32'((CHUNK_BYTES / 4 + (CHUNK_BYTES / 4) % 2) * 4);
    localparam logic FITS = (B0 <= HEAP_B - 32'd16);
    localparam logic [31:0] BRK_RST = FITS ? (32'd16 + B0) : 32'd16;
    localparam logic [2:0] INIT_LAST = FITS ? 3'd6 : 3'd3;

    function automatic logic [31:0] f_init_addr(input logic [2:0] k);
        case (k)
            3'd0:    return 32'd0;
            3'd1:    return 32'd4;
            3'd2:    return 32'd8;
            3'd3:    return 32'd12;
            3'd4:    return 32'd12;
            3'd5:    return B0 + 32'd8;
            default: return B0 + 32'd12;
        endcase
    endfunction

    function automatic logic [31:0] f_init_data(input logic [2:0] k);
        case (k)
            3'd0:    return 32'd0;
            3'd1:    return 32'd8 | BIT_ALLOC;
            3'd2:    return 32'd8 | BIT_ALLOC;
            3'd3:    return BOTH_BITS;
            3'd4:    return B0 | BIT_PREV;
            3'd5:    return B0;
            default: return BIT_ALLOC;
        endcase
    endfunction

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [31:0] r_break, n_break;
    logic        r_cmd, n_cmd;
    logic [15:0] r_req, n_req;
    logic [16:0] r_asize, n_asize;
    logic [32:0] r_p, n_p;
    logic [31:0] r_bp, n_bp;
    logic [31:0] r_own, n_own;
    logic [31:0] r_total, n_total;
    logic [31:0] r_nh, n_nh;
    logic [31:0] r_prev, n_prev;
    logic [31:0] r_t, n_t;
    logic        r_pu, n_pu;
    logic [15:0] r_res_addr, n_res_addr;
    logic [1:0]  r_res_stat, n_res_stat;

    logic [31:0]      s_base, s_off, s_wdata, s_q, s_qsz, s_asize32;
    logic [31:0]      s_ext, s_bytes, s_rest;
    logic [29:0]      s_ewords;
    logic             s_we;
    logic [IDX_W-1:0] s_idx;
    logic             s_fit, s_oom;

    ilha_agu #(.IDX_W(IDX_W)) u_agu (
        .i_base (s_base),
        .i_off  (s_off),
        .o_idx  (s_idx)
    );

    ilha_ram #(.IDX_W(IDX_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_idx   (s_idx),
        .i_wdata (s_wdata),
        .o_rdata (s_q)
    );

    assign s_qsz     = f_size(s_q);
    assign s_asize32 = {15'd0, r_asize};
    assign s_fit     = !s_q[0] && (s_qsz >= s_asize32);
    assign s_rest    = s_qsz - s_asize32;
    assign s_ext     = (s_asize32 > CHUNK_B) ? s_asize32 : CHUNK_B;
    // growth rounded to an even word count
    assign s_ewords  = s_ext[31:2] + {29'd0, s_ext[2]};
    assign s_bytes   = {s_ewords, 2'b00};
    assign s_oom     = (r_break > HEAP_B) || (s_bytes > HEAP_B - r_break);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_break <= BRK_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_break <= n_break;
        end
        r_cmd      <= n_cmd;
        r_req      <= n_req;
        r_asize    <= n_asize;
        r_p        <= n_p;
        r_bp       <= n_bp;
        r_own      <= n_own;
        r_total    <= n_total;
        r_nh       <= n_nh;
        r_prev     <= n_prev;
        r_t        <= n_t;
        r_pu       <= n_pu;
        r_res_addr <= n_res_addr;
        r_res_stat <= n_res_stat;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:    if (&r_cnt) n_state = ST_INIT;
            ST_INIT:     if (r_cnt[2:0] == INIT_LAST) n_state = ST_IDLE;
            ST_IDLE:     if (i_start) n_state = ST_START;
            ST_START: begin
                if (r_cmd == CMD_FREE) n_state = ST_RL0;
                else if (r_req == 16'd0) n_state = ST_DONE;
                else n_state = ST_FF_RD;
            end
            ST_FF_RD:    n_state = (r_p >= {1'b0, r_break}) ? ST_GROW_CHK : ST_FF_USE;
            ST_FF_USE: begin
                if (s_qsz == 32'd0) n_state = ST_GROW_CHK;
                else if (s_fit) n_state = ST_TK_RD;
                else n_state = ST_FF_RD;
            end
            ST_GROW_CHK: n_state = s_oom ? ST_DONE : ST_GR_RD;
            ST_GR_RD:    n_state = ST_GR_W0;
            ST_GR_W0:    n_state = ST_GR_W1;
            ST_GR_W1:    n_state = ST_GR_W2;
            ST_GR_W2:    n_state = ST_MG_RD0;
            ST_MG_RD0:   n_state = ST_MG_RD1;
            ST_MG_RD1:   n_state = ST_MG_DEC;
            ST_MG_DEC: begin
                if (r_pu && s_q[0]) n_state = ST_MG_END;
                else if (r_pu) n_state = ST_MP_W0;
                else if (s_q[0]) n_state = ST_MN_A;
                else n_state = ST_MB_A;
            end
            ST_MP_W0:    n_state = ST_MP_W1;
            ST_MP_W1:    n_state = ST_MG_END;
            ST_MN_A:     n_state = ST_MN_B;
            ST_MN_B:     n_state = ST_MN_C;
            ST_MN_C:     n_state = ST_MN_D;
            ST_MN_D:     n_state = ST_MG_END;
            ST_MB_A:     n_state = ST_MB_B;
            ST_MB_B:     n_state = ST_MB_C;
            ST_MB_C:     n_state = ST_MB_D;
            ST_MB_D:     n_state = ST_MB_E;
            ST_MB_E:     n_state = ST_MG_END;
            ST_MG_END:   n_state = (r_cmd == CMD_ALLOC) ? ST_TK_RD : ST_DONE;
            ST_TK_RD:    n_state = ST_TK_DEC;
            ST_TK_DEC:   n_state = (s_rest < 32'd8) ? ST_TK_NR : ST_TK_S1;
            ST_TK_NR:    n_state = ST_TK_NW;
            ST_TK_NW:    n_state = ST_DONE;
            ST_TK_S1:    n_state = ST_TK_S2;
            ST_TK_S2:    n_state = ST_DONE;
            ST_RL0:      n_state = ST_RL1;
            ST_RL1:      n_state = ST_RL2;
            ST_RL2:      n_state = ST_RL3;
            ST_RL3:      n_state = ST_RL4;
            ST_RL4:      n_state = ST_MG_RD0;
            ST_DONE:     if (i_slot_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // memory access and datapath updates
    always_comb begin
        s_we       = 1'b0;
        s_base     = r_bp;
        s_off      = 32'd0;
        s_wdata    = 32'd0;
        n_cnt      = r_cnt;
        n_break    = r_break;
        n_cmd      = r_cmd;
        n_req      = r_req;
        n_asize    = r_asize;
        n_p        = r_p;
        n_bp       = r_bp;
        n_own      = r_own;
        n_total    = r_total;
        n_nh       = r_nh;
        n_prev     = r_prev;
        n_t        = r_t;
        n_pu       = r_pu;
        n_res_addr = r_res_addr;
        n_res_stat = r_res_stat;
        case (r_state)
            ST_CLEAR: begin
                s_we   = 1'b1;
                s_base = 32'({r_cnt, 2'b00});
                n_cnt  = r_cnt + 1'b1;
            end
            ST_INIT: begin
                s_we    = 1'b1;
                s_base  = f_init_addr(r_cnt[2:0]);
                s_wdata = f_init_data(r_cnt[2:0]);
                n_cnt   = r_cnt + 1'b1;
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_cmd = i_command;
                    n_req = i_request_bytes;
                    n_bp  = {16'd0, i_block_address};
                end
            end
            ST_START: begin
                n_asize = (r_req <= 16'd4) ? 17'd8
                        : ({1'b0, r_req} + 17'd11) & 17'h1FFF8;
                n_p     = {1'b0, LIST_START};
                if (r_cmd == CMD_ALLOC && r_req == 16'd0) begin
                    n_res_addr = 16'd0;
                    n_res_stat = STAT_ZERO;
                end
            end
            ST_FF_RD: begin
                s_base = r_p[31:0];
                s_off  = OFF_M4;
            end
            ST_FF_USE: begin
                n_bp = r_p[31:0];
                n_p  = r_p + {1'b0, s_qsz};
            end
            ST_GROW_CHK: begin
                if (s_oom) begin
                    n_res_addr = 16'd0;
                    n_res_stat = STAT_OOM;
                end else begin
                    n_bp    = r_break;
                    n_own   = s_bytes;
                    n_t     = r_break + s_bytes;
                    n_break = r_break + s_bytes;
                end
            end
            ST_GR_RD: s_off = OFF_M4;
            ST_GR_W0: begin
                s_we    = 1'b1;
                s_off   = OFF_M4;
                s_wdata = r_own | (s_q & BIT_PREV);
            end
            ST_GR_W1: begin
                s_we    = 1'b1;
                s_base  = r_t;
                s_off   = OFF_M8;
                s_wdata = r_own;
            end
            ST_GR_W2: begin
                s_we    = 1'b1;
                s_base  = r_t;
                s_off   = OFF_M4;
                s_wdata = BIT_ALLOC;
            end
            ST_MG_RD0: s_off = OFF_M4;
            ST_MG_RD1: begin
                n_own = s_qsz;
                n_pu  = s_q[1];
                s_off = s_qsz + OFF_M4;
            end
            ST_MG_DEC: begin
                n_nh    = s_q;
                n_total = r_own + f_size(s_q);
                s_off   = OFF_M8;
            end
            ST_MP_W0: begin
                s_we    = 1'b1;
                s_off   = OFF_M4;
                s_wdata = r_total | BIT_PREV;
            end
            ST_MP_W1: begin
                s_we    = 1'b1;
                s_off   = r_total + OFF_M8;
                s_wdata = r_total;
            end
            ST_MN_A: begin
                n_total = r_own + s_qsz;
                s_we    = 1'b1;
                s_off   = r_own + OFF_M8;
                s_wdata = r_own + s_qsz;
            end
            ST_MN_B: s_off = OFF_M8;
            ST_MN_C: begin
                n_prev = r_bp - s_qsz;
                s_off  = OFF_M4 - s_qsz;
            end
            ST_MN_D: begin
                s_we    = 1'b1;
                s_base  = r_prev;
                s_off   = OFF_M4;
                s_wdata = r_total | (s_q & BIT_PREV);
                n_bp    = r_prev;
            end
            ST_MB_A: begin
                // both neighbours free: prev footer plus next header
                n_total = r_own + s_qsz + f_size(r_nh);
                n_prev  = r_bp - s_qsz;
                s_off   = OFF_M4 - s_qsz;
            end
            ST_MB_B: begin
                s_we    = 1'b1;
                s_base  = r_prev;
                s_off   = OFF_M4;
                s_wdata = r_total | (s_q & BIT_PREV);
            end
            ST_MB_C: s_off = OFF_M4;
            ST_MB_D: begin
                n_t   = r_bp + s_qsz;
                s_off = s_qsz + OFF_M4;
            end
            ST_MB_E: begin
                s_we    = 1'b1;
                s_base  = r_t;
                s_off   = s_qsz + OFF_M8;
                s_wdata = r_total;
                n_bp    = r_prev;
            end
            ST_MG_END: s_off = OFF_M4;
            ST_TK_RD: s_off = OFF_M4;
            ST_TK_DEC: begin
                n_t   = s_qsz;
                n_own = s_rest;
                s_we  = 1'b1;
                s_off = OFF_M4;
                if (s_rest < 32'd8) s_wdata = s_qsz | BOTH_BITS;
                else s_wdata = s_asize32 | BOTH_BITS;
            end
            ST_TK_NR: s_off = r_t + OFF_M4;
            ST_TK_NW: begin
                s_we       = 1'b1;
                s_off      = r_t + OFF_M4;
                s_wdata    = s_q | BIT_PREV;
                n_res_addr = r_bp[15:0];
                n_res_stat = STAT_OK;
            end
            ST_TK_S1: begin
                s_we    = 1'b1;
                s_off   = s_asize32 + OFF_M4;
                s_wdata = r_own | BIT_PREV;
            end
            ST_TK_S2: begin
                s_we       = 1'b1;
                s_off      = r_t + OFF_M8;
                s_wdata    = r_own;
                n_res_addr = r_bp[15:0];
                n_res_stat = STAT_OK;
            end
            ST_RL0: s_off = OFF_M4;
            ST_RL1: begin
                n_own   = s_qsz;
                s_we    = 1'b1;
                s_off   = OFF_M4;
                s_wdata = s_qsz | (s_q & BIT_PREV);
            end
            ST_RL2: begin
                s_we    = 1'b1;
                s_off   = r_own + OFF_M8;
                s_wdata = r_own;
            end
            ST_RL3: s_off = r_own + OFF_M4;
            ST_RL4: begin
                s_we       = 1'b1;
                s_off      = r_own + OFF_M4;
                s_wdata    = s_q & ~BIT_PREV;
                n_res_addr = 16'd0;
                n_res_stat = STAT_OK;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.idle = (r_state == ST_IDLE);
        o_status.done = (r_state == ST_DONE);
        o_status.addr = r_res_addr;
        o_status.stat = r_res_stat;
    end
endmodule

[src/implicit_list_heap_allocator_top.sv]
// heap allocator top level: handshakes and result register around the sequencer
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+-------------------------------------------
//  in       | i_in_valid   | o_in_ready   | i_command, i_request_bytes, i_block_address
//  out      | o_out_valid  | i_out_ready  | o_payload_address, o_status
//
// one transaction at a time; the single heap memory port does one access per cycle.
// allocate walks block headers first fit; growing the break at the walk end adds tag writes and a merge.
// after reset a clearing pass writes all HEAP_BYTES/4 words, then 4 to 7 setup
// writes, before o_in_ready rises.
// a result waits in the output register; the next transaction is taken meanwhile.
// a finished result holds the sequencer while the output register is still full.
`timescale 1ns / 1ps
module implicit_list_heap_allocator_top
    import ilha_pkg::*;
#(
    parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [15:0] i_request_bytes,
    input  logic [15:0] i_block_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_payload_address,
    output logic [1:0]  o_status
);
    t_seq_status s_seq;
    logic        s_slot_free, s_start;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_addr;
    logic [1:0]  r_stat;

    assign s_slot_free = !r_out_valid || i_out_ready;
    assign s_start     = i_in_valid && s_seq.idle;

    ilha_seq #(
        .HEAP_BYTES  (HEAP_BYTES),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (s_start),
        .i_command       (i_command),
        .i_request_bytes (i_request_bytes),
        .i_block_address (i_block_address),
        .i_slot_free     (s_slot_free),
        .o_status        (s_seq)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (s_seq.done && s_slot_free) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (s_seq.done && s_slot_free) begin
            r_addr <= s_seq.addr;
            r_stat <= s_seq.stat;
        end
    end

    assign o_in_ready        = s_seq.idle;
    assign o_out_valid       = r_out_valid;
    assign o_payload_address = r_addr;
    assign o_status          = r_stat;
endmodule
